// ----- rtl/scb_pkg.sv -----
// Shared types and constants of the system control block register file.
`default_nettype none

package scb_pkg;

    localparam int InFieldBits  = 66;
    localparam int InDataWidth  = 72;
    localparam int OutDataWidth = 40;

    localparam int RdataHi  = 31;
    localparam int StatusLo = 32;
    localparam int StatusHi = 33;
    localparam int PrioBit  = 34;
    localparam int FpcaBit  = 35;

    localparam logic [11:0] OffCpuid = 12'hD00;
    localparam logic [11:0] OffIcsr  = 12'hD04;
    localparam logic [11:0] OffVtor  = 12'hD08;
    localparam logic [11:0] OffAircr = 12'hD0C;
    localparam logic [11:0] OffScr   = 12'hD10;
    localparam logic [11:0] OffCcr   = 12'hD14;
    localparam logic [11:0] OffShpr1 = 12'hD18;
    localparam logic [11:0] OffShpr2 = 12'hD1C;
    localparam logic [11:0] OffShpr3 = 12'hD20;
    localparam logic [11:0] OffShcsr = 12'hD24;
    localparam logic [11:0] OffCfsr  = 12'hD28;
    localparam logic [11:0] OffHfsr  = 12'hD2C;
    localparam logic [11:0] OffCpacr = 12'hD88;
    localparam logic [11:0] OffFpccr = 12'hF34;

    localparam logic [1:0] SizeByte = 2'd0;
    localparam logic [1:0] SizeHalf = 2'd1;
    localparam logic [1:0] SizeWord = 2'd2;
    localparam logic [1:0] SizeLong = 2'd3;

    localparam logic CfgVtorReset = 1'b0;
    localparam logic CfgCpuid     = 1'b1;

    localparam logic [31:0] CpuidReset   = 32'h410F_C241;
    localparam logic [31:0] VtorReset    = 32'h0000_0000;
    localparam logic [15:0] AircrKey     = 16'h05FA;
    localparam logic [15:0] AircrRdHigh  = 16'hFA05;
    localparam logic [9:0]  CcrWriteMask = 10'h31B;
    localparam logic [9:0]  CcrReset     = 10'h200;

    localparam logic [3:0] ExcNmi     = 4'd2;
    localparam logic [3:0] ExcMem     = 4'd4;
    localparam logic [3:0] ExcUsage   = 4'd6;
    localparam logic [3:0] ExcSvc     = 4'd11;
    localparam logic [3:0] ExcDebug   = 4'd12;
    localparam logic [3:0] ExcPendsv  = 4'd14;
    localparam logic [3:0] ExcSystick = 4'd15;

    localparam int NumHandlerPrio = 12;

    typedef enum logic [1:0] {
        StatusOk      = 2'd0,
        StatusTooLong = 2'd1,
        StatusUnknown = 2'd2,
        StatusReset   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        RegCpuid,
        RegIcsr,
        RegVtor,
        RegAircr,
        RegScr,
        RegCcr,
        RegShpr1,
        RegShpr2,
        RegShpr3,
        RegShcsr,
        RegCfsr,
        RegHfsr,
        RegCpacr,
        RegFpccr,
        RegNone
    } reg_sel_t;

endpackage

`default_nettype wire

// ----- rtl/system_control_block_registers.sv -----
// System control block register file: one bus access per transaction.
//
// Usage: each s_ transaction is one read or write access (s_tuser is the
// opcode, 1 for write). Each accepted transaction yields exactly one m_
// transaction with read data, a status code and two flags for the core.
// The access passes an input register, one level of decode and merge
// logic and a result register: m_tvalid rises once the result register
// is loaded; one transaction per cycle is sustained with m_tready high.
// A write with OK status commits to the registers in the cycle it moves
// into the result register, so the next access always sees it.
// When the receiver stalls, the result register holds, the input
// register fills, and s_tready drops once both are occupied.
// Reset (rst_n low) clears both stages and loads every register with its
// architectural reset value; VTOR loads the constant VtorReset, so a
// write to config index 0 does not change what the next reset loads.
// CPUID reads return config index 1. The user writes the config port
// only while no transaction is in flight; the block does not enforce it.
`default_nettype none

module system_control_block_registers (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [31:0]                        cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // address[11:0], access_size[13:12], write_data[45:14],
    // current_exception[54:46], return_to_base[55], pending_vector[64:56],
    // external_pending[65], zero fill above
    input  wire logic [scb_pkg::InDataWidth-1:0]    s_tdata,
    // opcode
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // read_data[31:0], status[33:32], priorities_changed[34],
    // set_fp_context_active[35], zero fill above
    output logic [scb_pkg::OutDataWidth-1:0]        m_tdata
);
    import scb_pkg::*;

    logic                    in_valid_reg;
    logic [InFieldBits-1:0]  in_data_reg;
    logic                    in_write_reg;
    logic                    out_valid_reg;
    logic [OutDataWidth-1:0] out_data_reg;
    logic [OutDataWidth-1:0] out_data_next;
    logic                    advance;
    logic                    commit;

    logic [31:0] cpuid_reg;
    logic [31:0] vtor_reg;
    logic [3:0]  cpacr_reg;
    logic [31:0] fpccr_reg;
    logic [2:0]  prigroup_reg;
    logic [9:0]  ccr_reg;
    logic [31:0] scr_reg;
    logic [31:0] cfsr_reg;
    logic [31:0] hfsr_reg;
    logic [7:0]  prio_reg [NumHandlerPrio];
    logic [15:0] pend_reg;
    logic [15:0] act_reg;
    logic [1:0]  fault_en_reg;
    logic [15:0] pend_next;
    logic [15:0] act_next;
    logic [1:0]  fault_en_next;

    logic [11:0] address;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [8:0]  current_exception;
    logic        return_to_base;
    logic [8:0]  pending_vector;
    logic        external_pending;

    reg_sel_t    reg_sel;
    logic [31:0] cur;
    logic [3:0]  be;
    logic [4:0]  shamt;
    logic [31:0] lane_mask;
    logic [31:0] wshift;
    logic [31:0] merged;
    logic [31:0] rdata;
    logic        key_ok;
    status_t     status;
    logic        prio_flag;
    logic        fpca_flag;
    logic [1:0]  shpr_group;
    logic        shpr_hit;

    assign address           = in_data_reg[11:0];
    assign access_size       = in_data_reg[13:12];
    assign write_data        = in_data_reg[45:14];
    assign current_exception = in_data_reg[54:46];
    assign return_to_base    = in_data_reg[55];
    assign pending_vector    = in_data_reg[64:56];
    assign external_pending  = in_data_reg[65];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        unique case ({address[11:2], 2'b00})
            OffCpuid: reg_sel = RegCpuid;
            OffIcsr:  reg_sel = RegIcsr;
            OffVtor:  reg_sel = RegVtor;
            OffAircr: reg_sel = RegAircr;
            OffScr:   reg_sel = RegScr;
            OffCcr:   reg_sel = RegCcr;
            OffShpr1: reg_sel = RegShpr1;
            OffShpr2: reg_sel = RegShpr2;
            OffShpr3: reg_sel = RegShpr3;
            OffShcsr: reg_sel = RegShcsr;
            OffCfsr:  reg_sel = RegCfsr;
            OffHfsr:  reg_sel = RegHfsr;
            OffCpacr: reg_sel = RegCpacr;
            OffFpccr: reg_sel = RegFpccr;
            default:  reg_sel = RegNone;
        endcase
    end

    always_comb
    begin
        unique case (reg_sel)
            RegShpr1: shpr_group = 2'd0;
            RegShpr2: shpr_group = 2'd1;
            RegShpr3: shpr_group = 2'd2;
            default:  shpr_group = 2'd3;
        endcase
        shpr_hit = (shpr_group != 2'd3);
    end

    // Build the current read value of the addressed register.
    always_comb
    begin
        cur = '0;
        unique case (reg_sel)
            RegCpuid: cur = cpuid_reg;
            RegVtor:  cur = vtor_reg;
            RegCpacr: cur[23:20] = cpacr_reg;
            RegAircr: cur = {AircrRdHigh, 5'b0, prigroup_reg, 8'b0};
            RegShpr1: cur = {prio_reg[3], prio_reg[2], prio_reg[1], prio_reg[0]};
            RegShpr2: cur = {prio_reg[7], prio_reg[6], prio_reg[5], prio_reg[4]};
            RegShpr3: cur = {prio_reg[11], prio_reg[10], prio_reg[9], prio_reg[8]};
            RegFpccr: cur = fpccr_reg;
            RegCcr:   cur[9:0] = ccr_reg;
            RegScr:   cur = scr_reg;
            RegCfsr:  cur = cfsr_reg;
            RegHfsr:  cur = hfsr_reg;
            RegIcsr:
            begin
                cur[8:0]   = current_exception;
                cur[11]    = return_to_base;
                cur[20:12] = pending_vector;
                cur[22]    = external_pending;
                cur[26]    = pend_reg[ExcSystick];
                cur[28]    = pend_reg[ExcPendsv];
                cur[31]    = pend_reg[ExcNmi];
            end
            RegShcsr:
            begin
                cur[0]  = act_reg[ExcMem];
                cur[3]  = act_reg[ExcUsage];
                cur[7]  = act_reg[ExcSvc];
                cur[8]  = act_reg[ExcDebug];
                cur[10] = act_reg[ExcPendsv];
                cur[11] = act_reg[ExcSystick];
                cur[12] = pend_reg[ExcUsage];
                cur[13] = pend_reg[ExcMem];
                cur[15] = pend_reg[ExcSvc];
                cur[16] = fault_en_reg[0];
                cur[18] = fault_en_reg[1];
            end
            default:  cur = '0;
        endcase
    end

    // Select the lane from the access size and the low address bits.
    always_comb
    begin
        unique case (access_size)
            SizeByte:
            begin
                be        = 4'b0001 << address[1:0];
                shamt     = {address[1:0], 3'b000};
                lane_mask = 32'h0000_00FF;
            end
            SizeHalf:
            begin
                be        = address[1] ? 4'b1100 : 4'b0011;
                shamt     = {address[1], 4'b0000};
                lane_mask = 32'h0000_FFFF;
            end
            default:
            begin
                be        = 4'b1111;
                shamt     = 5'd0;
                lane_mask = 32'hFFFF_FFFF;
            end
        endcase
    end

    assign wshift = write_data << shamt;
    assign rdata  = (cur >> shamt) & lane_mask;

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            merged[8*b +: 8] = be[b] ? wshift[8*b +: 8] : cur[8*b +: 8];
        end
    end

    assign key_ok = (merged[31:16] == AircrKey);

    always_comb
    begin
        priority if (access_size == SizeLong)
            status = StatusTooLong;
        else if (reg_sel == RegNone)
            status = StatusUnknown;
        else if (in_write_reg && reg_sel == RegAircr && key_ok && merged[2])
            status = StatusReset;
        else
            status = StatusOk;
    end

    assign commit    = in_valid_reg && advance && in_write_reg && (status == StatusOk);
    assign prio_flag = in_write_reg && (status == StatusOk) &&
                       ((reg_sel == RegAircr && key_ok) || shpr_hit || reg_sel == RegShcsr);
    assign fpca_flag = in_write_reg && (status == StatusOk) &&
                       (reg_sel == RegFpccr) && merged[31];

    always_comb
    begin
        out_data_next = '0;
        if (!in_write_reg && status == StatusOk)
            out_data_next[RdataHi:0] = rdata;
        out_data_next[StatusHi:StatusLo] = status;
        out_data_next[PrioBit]           = prio_flag;
        out_data_next[FpcaBit]           = fpca_flag;
    end

    // Next exception state for ICSR and SHCSR writes.
    always_comb
    begin
        pend_next     = pend_reg;
        act_next      = act_reg;
        fault_en_next = fault_en_reg;
        unique case (reg_sel)
            RegIcsr:
            begin
                if (merged[31])
                    pend_next[ExcNmi] = 1'b1;
                if (merged[28])
                    pend_next[ExcPendsv] = 1'b1;
                else if (merged[27])
                    pend_next[ExcPendsv] = 1'b0;
                if (merged[26])
                    pend_next[ExcSystick] = 1'b1;
                else if (merged[25])
                    pend_next[ExcSystick] = 1'b0;
            end
            RegShcsr:
            begin
                act_next[ExcMem]     = merged[0];
                act_next[ExcUsage]   = merged[3];
                act_next[ExcSvc]     = merged[7];
                act_next[ExcDebug]   = merged[8];
                act_next[ExcPendsv]  = merged[10];
                act_next[ExcSystick] = merged[11];
                pend_next[ExcUsage]  = merged[12];
                pend_next[ExcMem]    = merged[13];
                pend_next[ExcSvc]    = merged[15];
                fault_en_next        = {merged[18], merged[16]};
            end
            default:
            begin
                pend_next     = pend_reg;
                act_next      = act_reg;
                fault_en_next = fault_en_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpuid_reg <= CpuidReset;
        end
        else if (cfg_we && cfg_index == CfgCpuid)
        begin
            cpuid_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtor_reg     <= VtorReset;
            cpacr_reg    <= '0;
            fpccr_reg    <= '0;
            prigroup_reg <= '0;
            ccr_reg      <= CcrReset;
            scr_reg      <= '0;
            cfsr_reg     <= '0;
            hfsr_reg     <= '0;
            pend_reg     <= '0;
            act_reg      <= '0;
            fault_en_reg <= '0;
            for (int i = 0; i < NumHandlerPrio; i++)
            begin
                prio_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            unique case (reg_sel)
                RegVtor:  vtor_reg <= merged;
                RegCpacr: cpacr_reg <= merged[23:20];
                RegAircr:
                begin
                    if (key_ok)
                        prigroup_reg <= merged[10:8];
                end
                RegFpccr: fpccr_reg <= merged;
                RegCcr:   ccr_reg <= merged[9:0] & CcrWriteMask;
                RegScr:   scr_reg <= merged;
                RegCfsr:  cfsr_reg <= merged;
                RegHfsr:  hfsr_reg <= merged;
                RegIcsr:  pend_reg <= pend_next;
                RegShcsr:
                begin
                    pend_reg     <= pend_next;
                    act_reg      <= act_next;
                    fault_en_reg <= fault_en_next;
                end
                RegShpr1, RegShpr2, RegShpr3:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        prio_reg[{shpr_group, 2'(k)}] <= merged[8*k +: 8];
                    end
                end
                default:
                begin
                    // CPUID: read only
                    vtor_reg <= vtor_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg  <= s_tdata[InFieldBits-1:0];
            in_write_reg <= s_tuser;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/scb_checker.sv -----
// Port-level checks of the system control block register file.
`default_nettype none

module scb_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [scb_pkg::OutDataWidth-1:0] m_tdata
);
    import scb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[StatusHi:StatusLo] != StatusOk |->
            m_tdata[RdataHi:0] == 32'd0 && !m_tdata[PrioBit] && !m_tdata[FpcaBit])
        else $error("error result carries data or flags");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!s_tvalid, 2) && $past(m_tready, 2) && $past(m_tready, 1) |-> !m_tvalid)
        else $error("result without an accepted transaction");

endmodule

bind system_control_block_registers scb_checker u_scb_checker (.*);

`default_nettype wire
